// ===== hw/rtl/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types, constants and the byte-wide CRC-32 update for the address
// frame checker.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam logic [31:0] CrcPoly         = 32'h04C1_1DB7;
  localparam logic [31:0] WindowLowReset  = 32'h0800_0000;
  localparam logic [31:0] WindowHighReset = 32'h0801_FFFF;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned AddrLen  = 4;

  localparam logic [2:0] LastByte = 3'(FrameLen - 1);
  localparam logic [2:0] AddrEnd  = 3'(AddrLen);

  typedef enum logic {
    CfgWindowLow  = 1'b0,
    CfgWindowHigh = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] address;
    logic        checksum_ok;
    logic        address_in_range;
  } afc_result_t;

  // MSB-first CRC over one byte, no reflection
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/crc32_address_frame_checker.sv =====
// ----------------------------------------------------------------------------
// crc32_address_frame_checker
// Checks 8-byte address frames (four big-endian address bytes, four CRC
// bytes) and reports the address when the CRC and flash window pass.
// ----------------------------------------------------------------------------
// Takes one byte transaction per cycle when not stalled. A byte is captured
// in an input register; the next cycle the byte-wide CRC-32 update (poly
// 0x04C11DB7, MSB first, init 0, no final XOR), address shift and window
// compare run in one combinational step, and on the eighth byte of a frame
// the verdict lands in a result register. frame_start restarts a frame at
// any byte. The input stalls only when a frame-ending byte waits on a
// stalled result register. Window registers (index 0 low, index 1 high,
// both inclusive) reset to 0x08000000 and 0x0801FFFF; the user must write
// them only while no frame is in flight, which the block does not enforce.
module crc32_address_frame_checker import afc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] address_o,
  output logic        checksum_ok_o,
  output logic        address_in_range_o
);

  logic        byte_valid, byte_start, last, out_free, advance;
  logic [7:0]  byte_data;
  afc_result_t core_res, out_res;

  assign advance = byte_valid & (~last | out_free);

  afc_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .consume_i     (advance),
    .valid_o       (byte_valid),
    .data_byte_o   (byte_data),
    .frame_start_o (byte_start)
  );

  afc_frame_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .advance_i     (advance),
    .data_byte_i   (byte_data),
    .frame_start_i (byte_start),
    .last_o        (last),
    .result_o      (core_res)
  );

  afc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance & last),
    .result_i    (core_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign address_o          = out_res.address;
  assign checksum_ok_o      = out_res.checksum_ok;
  assign address_in_range_o = out_res.address_in_range;

endmodule

// ===== hw/rtl/afc_in_reg.sv =====
// ----------------------------------------------------------------------------
// afc_in_reg
// Input register: captures one byte transaction and holds it until the
// frame logic consumes it.
// ----------------------------------------------------------------------------
module afc_in_reg import afc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_start_i,
  input  logic       consume_i,
  output logic       valid_o,
  output logic [7:0] data_byte_o,
  output logic       frame_start_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       start_q;
  logic       load;

  assign in_stall_o = valid_q & ~consume_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (consume_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q  <= data_byte_i;
      start_q <= frame_start_i;
    end
  end

  assign valid_o       = valid_q;
  assign data_byte_o   = data_q;
  assign frame_start_o = start_q;

endmodule

// ===== hw/rtl/afc_frame_core.sv =====
// ----------------------------------------------------------------------------
// afc_frame_core
// Frame state (byte count, CRC remainder, address) and the window registers;
// computes the verdict on the eighth byte.
// ----------------------------------------------------------------------------
module afc_frame_core import afc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        advance_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  output logic        last_o,
  output afc_result_t result_o
);

  logic [31:0] win_low_q, win_high_q;
  logic [2:0]  count_q, count_d, count_cur;
  logic [31:0] crc_q, crc_d, crc_base;
  logic [31:0] addr_q, addr_d, addr_base;
  logic        ok, in_range;

  always_comb begin
    count_cur = frame_start_i ? 3'd0 : count_q;
    crc_base  = (count_cur == 3'd0) ? 32'h0 : crc_q;
    addr_base = (count_cur == 3'd0) ? 32'h0 : addr_q;
    crc_d     = crc_byte(crc_base, data_byte_i);
    addr_d    = (count_cur < AddrEnd) ? {addr_base[23:0], data_byte_i} : addr_base;
    count_d   = count_cur + 3'd1;
    last_o    = (count_cur == LastByte);
    ok        = (crc_d == 32'h0);
    in_range  = (addr_d >= win_low_q) && (addr_d <= win_high_q);
    result_o.address          = (ok && in_range) ? addr_d : 32'h0;
    result_o.checksum_ok      = ok;
    result_o.address_in_range = in_range;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
      crc_q   <= 32'h0;
      addr_q  <= 32'h0;
    end else if (advance_i) begin
      count_q <= count_d;
      crc_q   <= crc_d;
      addr_q  <= addr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_low_q  <= WindowLowReset;
      win_high_q <= WindowHighReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgWindowLow:  win_low_q  <= cfg_wdata_i;
        CfgWindowHigh: win_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/afc_out_reg.sv =====
// ----------------------------------------------------------------------------
// afc_out_reg
// Result register: holds one verdict transaction until the sink takes it.
// ----------------------------------------------------------------------------
module afc_out_reg import afc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  afc_result_t result_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output afc_result_t result_o
);

  logic        valid_q;
  afc_result_t res_q;

  assign free_o = ~valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

// ===== dv/crc32_address_frame_checker_test.sv =====
// ----------------------------------------------------------------------------
// crc32_address_frame_checker_test
// Self-checking bench: streams address frames byte by byte with random
// idling on both sides. A local CRC-32 and window tracker predicts each
// frame verdict. Windows are reprogrammed between phases: reset, full,
// empty, single address and random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc32_address_frame_checker_test;
  import afc_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        frame_start_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] address_o;
  logic        checksum_ok_o;
  logic        address_in_range_o;

  afc_result_t pending_verdicts[$];
  afc_result_t verdict_head;
  logic [2:0]  frame_pos;
  logic [31:0] crc_acc;
  logic [31:0] addr_acc;
  logic [31:0] win_lo;
  logic [31:0] win_hi;
  int unsigned mismatch_count;
  int unsigned bytes_sent;
  int unsigned stall_left;
  bit          steady;

  crc32_address_frame_checker i_dut (.*);

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[31] ^ b[i];
      c = {c[30:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] frame_crc(logic [31:0] addr);
    logic [31:0] c;
    c = '0;
    for (int i = 3; i >= 0; i--) begin
      c = crc_step(c, addr[8*i +: 8]);
    end
    return c;
  endfunction

  function automatic int unsigned idle_draw();
    if (steady) begin
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic track_frame_byte(input logic [7:0] b, input logic s);
    afc_result_t v;
    logic        in_win;
    if (s) begin
      frame_pos = '0;
    end
    if (frame_pos == '0) begin
      crc_acc  = '0;
      addr_acc = '0;
    end
    crc_acc = crc_step(crc_acc, b);
    if (frame_pos < AddrEnd) begin
      addr_acc = {addr_acc[23:0], b};
    end
    if (frame_pos == LastByte) begin
      in_win             = (addr_acc >= win_lo) && (addr_acc <= win_hi);
      v.checksum_ok      = (crc_acc == '0);
      v.address_in_range = in_win;
      v.address          = (v.checksum_ok && in_win) ? addr_acc : '0;
      pending_verdicts.push_back(v);
      frame_pos = '0;
    end else begin
      frame_pos++;
    end
  endtask

  // result side: random stall after each transaction, compare against oldest verdict
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("unexpected result address %h", address_o));
      end else begin
        verdict_head = pending_verdicts.pop_front();
        if (address_o !== verdict_head.address) begin
          flag_mismatch($sformatf("address got %h want %h", address_o,
                                  verdict_head.address));
        end
        if (checksum_ok_o !== verdict_head.checksum_ok) begin
          flag_mismatch($sformatf("checksum_ok got %b want %b", checksum_ok_o,
                                  verdict_head.checksum_ok));
        end
        if (address_in_range_o !== verdict_head.address_in_range) begin
          flag_mismatch($sformatf("address_in_range got %b want %b",
                                  address_in_range_o, verdict_head.address_in_range));
        end
      end
      stall_left = idle_draw();
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    int unsigned gap;
    gap = idle_draw();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    frame_start_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    track_frame_byte(b, s);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [31:0] addr, input logic [31:0] chk,
                            input logic first_start);
    logic [63:0] word;
    word = {addr, chk};
    for (int i = 0; i < 8; i++) begin
      send_byte(word[63-8*i -: 8], (i == 0) ? first_start : 1'b0);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgWindowLow) begin
      win_lo = val;
    end else begin
      win_hi = val;
    end
  endtask

  task automatic set_window(input logic [31:0] lo, input logic [31:0] hi);
    drain();
    write_cfg(CfgWindowLow, lo);
    write_cfg(CfgWindowHigh, hi);
  endtask

  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    logic [63:0] span;
    logic [63:0] r;
    a = $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        if (win_lo <= win_hi) begin
          span = {32'd0, win_hi} - {32'd0, win_lo} + 64'd1;
          r    = {$urandom, $urandom} % span;
          a    = win_lo + r[31:0];
        end
      end
      3: a = win_lo;
      4: a = win_hi;
      5: a = $urandom_range(0, 1) ? win_lo - 32'd1 : win_hi + 32'd1;
      6: a = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default: ;
    endcase
    return a;
  endfunction

  // mostly well-formed frames, some with bad CRC, some stray or aborted bytes
  task automatic send_random_traffic(input int unsigned n);
    int unsigned stop;
    int unsigned kind;
    int unsigned len;
    logic [31:0] addr;
    logic [31:0] chk;
    logic        s;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        len = $urandom_range(1, 7);
        repeat (len) send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
      end else begin
        addr = pick_address();
        chk  = frame_crc(addr);
        if (kind == 1) begin
          chk ^= 32'd1 << $urandom_range(0, 31);
        end else if (kind == 2 && $urandom_range(0, 1) == 1) begin
          chk = $urandom;
        end
        s = (frame_pos != '0) ? 1'b1 : 1'($urandom_range(0, 1));
        send_frame(addr, chk, s);
      end
    end
  endtask

  task automatic test_directed();
    steady = 1'b0;
    send_byte(8'hFF, 1'b1);
    // restart mid-frame, then a back-to-back frame relying on the wrap
    send_frame(WindowLowReset, frame_crc(WindowLowReset), 1'b1);
    send_frame(WindowHighReset, frame_crc(WindowHighReset), 1'b0);
    // in range but bad CRC
    send_frame(32'h0800_0100, frame_crc(32'h0800_0100) ^ 32'h1, 1'b0);
  endtask

  task automatic test_full_window();
    set_window(32'h0000_0000, 32'hFFFF_FFFF);
    send_frame(32'h0000_0000, frame_crc(32'h0000_0000), 1'b1);
    send_frame(32'hFFFF_FFFF, frame_crc(32'hFFFF_FFFF), 1'b0);
    send_random_traffic(200);
  endtask

  task automatic test_empty_window();
    logic [31:0] x;
    set_window(32'hFFFF_FFFF, 32'h0000_0000);
    send_random_traffic(150);
    x = $urandom;
    set_window(x, x - 32'd1);
    send_random_traffic(50);
  endtask

  task automatic test_single_address();
    logic [31:0] x;
    x = $urandom;
    set_window(x, x);
    send_random_traffic(150);
  endtask

  task automatic test_random_windows();
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] t;
    repeat (4) begin
      lo = $urandom;
      hi = $urandom;
      if (lo > hi && $urandom_range(0, 3) != 0) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      set_window(lo, hi);
      steady = ($urandom_range(0, 2) == 0);
      send_random_traffic(150);
    end
    steady = 1'b0;
  endtask

  task automatic test_reset_window();
    set_window(WindowLowReset, WindowHighReset);
    steady = 1'b1;
    send_random_traffic(100);
    steady = 1'b0;
    send_random_traffic(50);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CfgWindowLow;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    data_byte_i   <= '0;
    frame_start_i <= 1'b0;
    out_stall_i   <= 1'b0;
    win_lo         = WindowLowReset;
    win_hi         = WindowHighReset;
    frame_pos      = '0;
    crc_acc        = '0;
    addr_acc       = '0;
    mismatch_count = 0;
    bytes_sent     = 0;
    stall_left     = 0;
    steady         = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_window();
    test_empty_window();
    test_single_address();
    test_random_windows();
    test_reset_window();
    drain();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/afc_pkg.sv
hw/rtl/afc_in_reg.sv
hw/rtl/afc_frame_core.sv
hw/rtl/afc_out_reg.sv
hw/rtl/crc32_address_frame_checker.sv
dv/crc32_address_frame_checker_test.sv
